// ----- rtl/adpcm_pkg.sv -----
package adpcm_pkg;

  localparam int BLOCK_FRAMES = 4096;
  localparam int FRAME_W = $clog2(BLOCK_FRAMES);

  localparam int INDEX_MAX = 88;
  localparam int INIT_INDEX_MAX = 63;

  localparam logic [21:0] HDR_VALUE = 22'd2;
  localparam logic [4:0] WIDTH_HDR = 5'd2;
  localparam logic [4:0] WIDTH_INIT = 5'd22;
  localparam logic [4:0] WIDTH_CODE = 5'd4;

  localparam logic [14:0] STEP_TAB [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
    15'd29794, 15'd32767
  };

  typedef struct packed {
    logic load;
    logic load_hdr;
    logic search_step;
    logic enc_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_hdr;
    logic block_start;
    logic search_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [14:0] step_of(input logic [6:0] idx);
    logic [14:0] r;
    if (idx > 7'(INDEX_MAX)) begin
      r = STEP_TAB[INDEX_MAX];
    end else begin
      r = STEP_TAB[idx];
    end
    return r;
  endfunction

  function automatic logic signed [4:0] index_adj(input logic [2:0] mag);
    logic signed [4:0] r;
    case (mag)
      3'd4: r = 5'sd2;
      3'd5: r = 5'sd4;
      3'd6: r = 5'sd6;
      3'd7: r = 5'sd8;
      default: r = -5'sd1;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/adpcm_ifs.sv -----
interface adpcm_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] pcm_sample;
  logic signed [15:0] lookahead_sample;
  modport source(output valid, output pcm_sample, output lookahead_sample, input ready);
  modport sink(input valid, input pcm_sample, input lookahead_sample, output ready);
endinterface

interface adpcm_chunk_if;
  logic valid;
  logic ready;
  logic [21:0] chunk_value;
  logic [4:0] chunk_width;
  logic last_of_item;
  modport source(output valid, output chunk_value, output chunk_width,
                 output last_of_item, input ready);
  modport sink(input valid, input chunk_value, input chunk_width,
               input last_of_item, output ready);
endinterface

interface adpcm_cfg_if;
  logic valid;
  logic ready;
  logic stereo_mode;
  modport source(output valid, output stereo_mode, input ready);
  modport sink(input valid, input stereo_mode, output ready);
endinterface

// ----- rtl/adpcm_ctrl.sv -----
module adpcm_ctrl import adpcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_SEARCH,
    S_ENC,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic [1:0] k_q, k_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d = 2'd0;
          if (status_i.need_hdr) begin
            state_d = S_HDR;
          end else if (status_i.block_start) begin
            state_d = S_SEARCH;
          end else begin
            state_d = S_ENC;
          end
        end
      end
      S_HDR: begin
        if (status_i.out_free) begin
          cmd_o.load_hdr = 1'b1;
          state_d = status_i.block_start ? S_SEARCH : S_ENC;
        end
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_done) begin
          state_d = S_FIN;
        end
      end
      S_ENC: begin
        cmd_o.enc_step = 1'b1;
        k_d = k_q + 2'd1;
        if (k_q == 2'd2) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= 2'd0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
    end
  end

`ifndef SYNTHESIS
  a_enc_three_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC && k_q == 2'd2) |=> (state_q == S_FIN))
    else $error("encoder left the magnitude steps early or late");
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE && in_valid_i))
    else $error("sample loaded outside idle");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC) |-> (k_q != 2'd3))
    else $error("step counter out of range");
`endif

endmodule

// ----- rtl/adpcm_dp.sv -----
module adpcm_dp import adpcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_stereo_i,
  input  logic signed [15:0] pcm_sample_i,
  input  logic signed [15:0] lookahead_sample_i,
  input  logic               chunk_ready_i,
  output logic               chunk_valid_o,
  output logic [21:0]        chunk_value_o,
  output logic [4:0]         chunk_width_o,
  output logic               last_of_item_o,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o
);

  logic stereo_q;
  logic header_done_q;
  logic chan_q;
  logic [FRAME_W-1:0] frame_q;
  logic signed [15:0] pred_q [2];
  logic [6:0] idx_q [2];

  logic ch_q;
  logic block_q;
  logic signed [15:0] s_q;
  logic [16:0] ad_q;
  logic [16:0] diff_q;
  logic [14:0] step_q;
  logic [16:0] vp_q;
  logic [2:0] delta_q;
  logic sign_q;
  logic [5:0] si_q;

  logic out_valid_q;
  logic [21:0] out_value_q;
  logic [4:0] out_width_q;
  logic out_last_q;

  logic signed [15:0] pred_cur;
  logic [6:0] idx_cur;
  logic signed [16:0] sdiff;
  logic signed [16:0] adiff;
  logic [14:0] step_ld;
  logic search_hit;
  logic enc_hit;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_new;
  logic signed [7:0] idx_sum;
  logic [6:0] idx_new;
  logic [2:0] adj_sel;

  assign pred_cur = pred_q[chan_q];
  assign idx_cur = idx_q[chan_q];
  assign sdiff = {pcm_sample_i[15], pcm_sample_i} - {pred_cur[15], pred_cur};
  assign adiff = {lookahead_sample_i[15], lookahead_sample_i}
               - {pcm_sample_i[15], pcm_sample_i};
  assign step_ld = step_of(idx_cur);

  assign search_hit = (ad_q <= {2'b00, STEP_TAB[si_q]}) || (si_q == 6'(INIT_INDEX_MAX));
  assign enc_hit = (diff_q >= {2'b00, step_q});

  assign pred_sum = {{2{pred_q[ch_q][15]}}, pred_q[ch_q]}
                  + (sign_q ? -$signed({1'b0, vp_q}) : $signed({1'b0, vp_q}));
  always_comb begin
    if (pred_sum > 18'sd32767) begin
      pred_new = 16'sh7fff;
    end else if (pred_sum < -18'sd32768) begin
      pred_new = -16'sh8000;
    end else begin
      pred_new = pred_sum[15:0];
    end
  end

  assign adj_sel = delta_q;
  assign idx_sum = $signed({1'b0, idx_q[ch_q]}) + 8'(index_adj(adj_sel));
  always_comb begin
    if (idx_sum < 8'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > 8'(INDEX_MAX)) begin
      idx_new = 7'(INDEX_MAX);
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  assign status_o.need_hdr = !header_done_q;
  assign status_o.block_start = (frame_q == '0);
  assign status_o.search_done = search_hit;
  assign status_o.out_free = !out_valid_q || chunk_ready_i;

  assign chunk_valid_o = out_valid_q;
  assign chunk_value_o = out_value_q;
  assign chunk_width_o = out_width_q;
  assign last_of_item_o = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q <= 1'b0;
      header_done_q <= 1'b0;
      chan_q <= 1'b0;
      frame_q <= '0;
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      idx_q[0] <= '0;
      idx_q[1] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        stereo_q <= cfg_stereo_i;
      end
      if (cmd_i.load_hdr) begin
        header_done_q <= 1'b1;
      end
      if (cmd_i.load_hdr || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (chunk_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (block_q) begin
          pred_q[ch_q] <= s_q;
          idx_q[ch_q] <= {1'b0, si_q};
        end else begin
          pred_q[ch_q] <= pred_new;
          idx_q[ch_q] <= idx_new;
        end
        if (stereo_q && !ch_q) begin
          chan_q <= 1'b1;
        end else begin
          chan_q <= 1'b0;
          if (frame_q == FRAME_W'(BLOCK_FRAMES - 1)) begin
            frame_q <= '0;
          end else begin
            frame_q <= frame_q + FRAME_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= chan_q;
      block_q <= (frame_q == '0);
      s_q <= pcm_sample_i;
      ad_q <= adiff[16] ? 17'(-adiff) : 17'(adiff);
      diff_q <= sdiff[16] ? 17'(-sdiff) : 17'(sdiff);
      sign_q <= sdiff[16];
      step_q <= step_ld;
      vp_q <= {5'd0, step_ld[14:3]};
      delta_q <= 3'd0;
      si_q <= 6'd0;
    end
    if (cmd_i.search_step && !search_hit) begin
      si_q <= si_q + 6'd1;
    end
    if (cmd_i.enc_step) begin
      if (enc_hit) begin
        diff_q <= diff_q - {2'b00, step_q};
        vp_q <= vp_q + {2'b00, step_q};
      end
      step_q <= {1'b0, step_q[14:1]};
      delta_q <= {delta_q[1:0], enc_hit};
    end
    if (cmd_i.load_hdr) begin
      out_value_q <= HDR_VALUE;
      out_width_q <= WIDTH_HDR;
      out_last_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_last_q <= 1'b1;
      if (block_q) begin
        out_value_q <= {s_q, si_q};
        out_width_q <= WIDTH_INIT;
      end else begin
        out_value_q <= {18'd0, sign_q, delta_q};
        out_width_q <= WIDTH_CODE;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_hdr || cmd_i.finish) |-> (!out_valid_q || chunk_ready_i))
    else $error("output word overwritten before it was taken");
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q[0] <= 7'(INDEX_MAX)) && (idx_q[1] <= 7'(INDEX_MAX)))
    else $error("step index left its range");
  a_mono_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !stereo_q) |=> !chan_q)
    else $error("mono stream moved to channel 1");
  a_header_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_done_q |=> header_done_q)
    else $error("header flag cleared");
`endif

endmodule

// ----- rtl/block_adpcm_encoder_4bit_top.sv -----
// IMA-style 4-bit ADPCM encoder that turns 16-bit PCM samples into bit chunks.
// The sample channel carries one word per sample together with a later
// sample of the same channel, which is only used at a block start to choose
// the initial step index. The chunk channel carries words of 2, 22 or 4 valid
// low bits, to be appended MSB first; last_of_item marks the final word of a
// sample. The configuration channel writes stereo_mode and is always ready;
// the user must write it only while the encoder is idle; it is not enforced.
// One sample is taken at a time. An ordinary sample passes through a load
// state in which it is accepted and loaded, three magnitude steps through
// the shared compare-and-subtract unit, and a store state that puts its word
// into the output register; the next sample is taken only after that store.
// A block-start sample instead walks the step table one entry per cycle, up
// to entry 63, between the load and the store. The very first sample also
// passes a header state that stores the header word first. A finished word
// waits in the output register while the next sample is accepted; if the
// receiver stalls, the encoder holds before storing its next word until the
// register is free.
// Reset clears predictors, step indexes, frame counter, channel and header
// flag, and returns stereo_mode to mono.
module block_adpcm_encoder_4bit_top import adpcm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  adpcm_cfg_if.sink cfg_i,
  adpcm_sample_if.sink sample_i,
  adpcm_chunk_if.source chunk_o
);

  dp_cmd_t cmd;
  dp_status_t status;
  logic in_ready;

  assign cfg_i.ready = 1'b1;
  assign sample_i.ready = in_ready;

  adpcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adpcm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_stereo_i       (cfg_i.stereo_mode),
    .pcm_sample_i       (sample_i.pcm_sample),
    .lookahead_sample_i (sample_i.lookahead_sample),
    .chunk_ready_i      (chunk_o.ready),
    .chunk_valid_o      (chunk_o.valid),
    .chunk_value_o      (chunk_o.chunk_value),
    .chunk_width_o      (chunk_o.chunk_width),
    .last_of_item_o     (chunk_o.last_of_item),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

// ----- tb/sv/adpcm_chunk_checker.sv -----
module adpcm_chunk_checker import adpcm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  adpcm_cfg_if cfg_i,
  adpcm_sample_if sample_i,
  adpcm_chunk_if chunk_i,
  output int mismatch_count_o,
  output int words_pending_o
);

  localparam int PCM_MAX = 32767;
  localparam int PCM_MIN = -32768;
  localparam int INDEX_MOVE [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  typedef struct packed {
    logic [21:0] value;
    logic [4:0] width;
    logic last;
  } chunk_word_t;

  logic stereo_q;
  logic signed [15:0] pred_q [2];
  logic [6:0] idx_q [2];
  int frame_q;
  logic chan_q;
  logic hdr_sent_q;
  chunk_word_t expected_words [$];
  int mismatches = 0;

  function automatic logic [5:0] start_index(input logic signed [15:0] pcm,
                                             input logic signed [15:0] ahead);
    int gap_abs;
    int i;
    gap_abs = int'(ahead) - int'(pcm);
    if (gap_abs < 0) begin
      gap_abs = -gap_abs;
    end
    i = 0;
    while (i < INDEX_MAX && gap_abs > int'(STEP_TAB[i])) begin
      i++;
    end
    if (i > INIT_INDEX_MAX) begin
      i = INIT_INDEX_MAX;
    end
    return 6'(i);
  endfunction

  function automatic logic [3:0] code_sample(input logic ch, input logic signed [15:0] pcm);
    int idx;
    int step;
    int diff;
    int vpdiff;
    int pred;
    int k;
    logic [2:0] mag;
    logic sgn;
    idx = int'(idx_q[ch]);
    if (idx > INDEX_MAX) begin
      idx = INDEX_MAX;
    end
    step = int'(STEP_TAB[idx]);
    diff = int'(pcm) - int'(pred_q[ch]);
    sgn = 1'b0;
    if (diff < 0) begin
      sgn = 1'b1;
      diff = -diff;
    end
    vpdiff = step >>> 3;
    mag = '0;
    for (k = 2; k >= 0; k--) begin
      if (diff >= step) begin
        mag[k] = 1'b1;
        vpdiff += step;
        if (k > 0) begin
          diff -= step;
        end
      end
      step = step >>> 1;
    end
    pred = int'(pred_q[ch]) + (sgn ? -vpdiff : vpdiff);
    if (pred > PCM_MAX) begin
      pred = PCM_MAX;
    end else if (pred < PCM_MIN) begin
      pred = PCM_MIN;
    end
    pred_q[ch] = 16'(pred);
    idx = idx + INDEX_MOVE[mag];
    if (idx < 0) begin
      idx = 0;
    end
    if (idx > INDEX_MAX) begin
      idx = INDEX_MAX;
    end
    idx_q[ch] = 7'(idx);
    return {sgn, mag};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("chunk word mismatch at %0t: %s got 0x%0h expected 0x%0h",
             $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_words(input logic signed [15:0] pcm,
                               input logic signed [15:0] ahead);
    logic ch;
    logic [5:0] first_idx;
    chunk_word_t w;
    ch = chan_q;
    if (!hdr_sent_q) begin
      w.value = HDR_VALUE;
      w.width = WIDTH_HDR;
      w.last = 1'b0;
      expected_words.push_back(w);
      hdr_sent_q = 1'b1;
    end
    if (frame_q == 0) begin
      first_idx = start_index(pcm, ahead);
      pred_q[ch] = pcm;
      idx_q[ch] = 7'(first_idx);
      w.value = {pcm, first_idx};
      w.width = WIDTH_INIT;
    end else begin
      w.value = 22'(code_sample(ch, pcm));
      w.width = WIDTH_CODE;
    end
    w.last = 1'b1;
    expected_words.push_back(w);
    if (stereo_q && !ch) begin
      chan_q = 1'b1;
    end else begin
      chan_q = 1'b0;
      frame_q = (frame_q == BLOCK_FRAMES - 1) ? 0 : frame_q + 1;
    end
  endtask

  task automatic check_word(input logic [21:0] value, input logic [4:0] width,
                            input logic last);
    chunk_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("word with none pending, value", int'(value), 0);
    end else begin
      w = expected_words.pop_front();
      if (value !== w.value) begin
        report_mismatch("chunk_value", int'(value), int'(w.value));
      end
      if (width !== w.width) begin
        report_mismatch("chunk_width", int'(width), int'(w.width));
      end
      if (last !== w.last) begin
        report_mismatch("last_of_item", int'(last), int'(w.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q = 1'b0;
      pred_q[0] = '0;
      pred_q[1] = '0;
      idx_q[0] = '0;
      idx_q[1] = '0;
      frame_q = 0;
      chan_q = 1'b0;
      hdr_sent_q = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        stereo_q = cfg_i.stereo_mode;
      end
      if (sample_i.valid && sample_i.ready) begin
        predict_words(sample_i.pcm_sample, sample_i.lookahead_sample);
      end
      if (chunk_i.valid && chunk_i.ready) begin
        check_word(chunk_i.chunk_value, chunk_i.chunk_width, chunk_i.last_of_item);
      end
    end
    words_pending_o = expected_words.size();
    mismatch_count_o = mismatches;
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

  localparam logic signed [15:0] PCM_HI = 16'h7fff;
  localparam logic signed [15:0] PCM_LO = 16'h8000;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 30;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 155;

  logic clk;
  logic rst_n;
  int mismatches;
  int words_pending;

  pace_t pace;
  logic stereo_now;
  logic chan_now;
  int walk [2];

  adpcm_cfg_if cfg_bus();
  adpcm_sample_if sample_bus();
  adpcm_chunk_if chunk_bus();

  block_adpcm_encoder_4bit_top u_dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_i(cfg_bus.sink),
    .sample_i(sample_bus.sink),
    .chunk_o(chunk_bus.source)
  );

  adpcm_chunk_checker u_checker (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_i(cfg_bus),
    .sample_i(sample_bus),
    .chunk_i(chunk_bus),
    .mismatch_count_o(mismatches),
    .words_pending_o(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_cycles();
    int w;
    case (pace)
      PACE_FULL: begin
        w = 0;
      end
      PACE_LIGHT: begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end
      default: begin
        w = $urandom_range(0, 18);
      end
    endcase
    return w;
  endfunction

  // Mostly a random walk per channel at a random scale, with some noise
  // and some full-scale values mixed in.
  function automatic logic signed [15:0] next_pcm(input logic ch);
    int v;
    int r;
    logic signed [15:0] d;
    r = $urandom_range(0, 31);
    d = 16'($urandom);
    if (r == 0) begin
      v = $urandom_range(0, 1) ? int'(PCM_HI) : int'(PCM_LO);
    end else if (r < 4) begin
      v = int'(d);
    end else begin
      v = walk[ch] + int'(d >>> $urandom_range(0, 15));
      if (v > int'(PCM_HI)) begin
        v = int'(PCM_HI);
      end else if (v < int'(PCM_LO)) begin
        v = int'(PCM_LO);
      end
    end
    walk[ch] = v;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] lookahead_for(input logic signed [15:0] pcm);
    logic signed [15:0] d;
    logic signed [15:0] a;
    d = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      a = d;
    end else begin
      a = pcm + (d >>> $urandom_range(0, 15));
    end
    return a;
  endfunction

  task automatic send_sample(input logic signed [15:0] pcm, input logic signed [15:0] ahead);
    int w;
    w = idle_cycles();
    if (w > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    sample_bus.pcm_sample <= pcm;
    sample_bus.lookahead_sample <= ahead;
    sample_bus.valid <= 1'b1;
    do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
    @(negedge clk);
    if (stereo_now && !chan_now) begin
      chan_now = 1'b1;
    end else begin
      chan_now = 1'b0;
    end
  endtask

  task automatic send_random();
    logic signed [15:0] pcm;
    pcm = next_pcm(chan_now);
    send_sample(pcm, lookahead_for(pcm));
  endtask

  task automatic write_mode(input logic mode);
    cfg_bus.stereo_mode <= mode;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    stereo_now = mode;
  endtask

  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The receiver draws a stall of random length, possibly none, before every word.
  initial begin
    int w;
    chunk_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      w = idle_cycles();
      if (w > 0) begin
        chunk_bus.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      chunk_bus.ready <= 1'b1;
      do @(posedge clk); while (!(chunk_bus.valid && chunk_bus.ready));
      @(negedge clk);
    end
  end

  initial begin
    int stall;
    stall = 0;
    wait (rst_n === 1'b1);
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_bus.valid && sample_bus.ready) || (chunk_bus.valid && chunk_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("block_adpcm_encoder_4bit_top test failed");
    $finish;
  end

  initial begin
    int p;
    int i;
    cfg_bus.valid = 1'b0;
    cfg_bus.stereo_mode = 1'b0;
    sample_bus.valid = 1'b0;
    sample_bus.pcm_sample = '0;
    sample_bus.lookahead_sample = '0;
    pace = PACE_LIGHT;
    stereo_now = 1'b0;
    chan_now = 1'b0;
    walk[0] = 0;
    walk[1] = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Header and block start on both channels, then saturation of both
    // predictors, step index clamping at both ends and full-scale swings.
    write_mode(1'b1);
    send_sample(PCM_LO, PCM_HI);
    send_sample(16'sd0, 16'sd0);
    send_sample(PCM_HI, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    for (i = 0; i < 6; i++) begin
      send_sample(PCM_HI, -16'sd1);
      send_sample(PCM_LO, 16'sd1);
    end
    for (i = 0; i < 2; i++) begin
      send_sample(PCM_LO, 16'sd0);
      send_sample(PCM_HI, 16'sd0);
    end
    send_sample(-16'sd1, 16'sd0);

    // Switch to mono with channel 1 still due: that sample closes the frame.
    settle();
    write_mode(1'b0);
    send_sample(16'sd1, 16'sd7);
    send_sample(PCM_HI, PCM_LO);
    send_sample(16'sd0, -16'sd1);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_mode(1'b1);
      end else if (p == 1) begin
        write_mode(1'b0);
      end else begin
        write_mode(1'($urandom_range(0, 1)));
      end
      pace = pace_t'(p % 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_random();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("block_adpcm_encoder_4bit_top test passed");
    end else begin
      $display("block_adpcm_encoder_4bit_top test failed");
    end
    $finish;
  end

endmodule

// ----- block_adpcm_encoder_4bit_top.f -----
rtl/adpcm_pkg.sv
rtl/adpcm_ifs.sv
rtl/adpcm_ctrl.sv
rtl/adpcm_dp.sv
rtl/block_adpcm_encoder_4bit_top.sv
tb/sv/adpcm_chunk_checker.sv
tb/sv/tb.sv
